[hw/rtl/cfsc_pkg.sv]
// Shared types, field codes and limits for the clock field set controller.
// Used by cfsc_edit and clock_field_set_controller_unit; no dependencies.
`timescale 1ns / 1ps

package cfsc_pkg;

  // Field codes carried in field_select
  localparam logic [2:0] FS_SEC   = 3'd0;
  localparam logic [2:0] FS_MIN   = 3'd1;
  localparam logic [2:0] FS_HOUR  = 3'd2;
  localparam logic [2:0] FS_DAY   = 3'd3;
  localparam logic [2:0] FS_MONTH = 3'd4;
  localparam logic [2:0] FS_YEAR  = 3'd5;

  // Edit modes
  localparam logic [2:0] MODE_RUN   = 3'd0;
  localparam logic [2:0] MODE_DAY   = 3'd1;
  localparam logic [2:0] MODE_MONTH = 3'd2;
  localparam logic [2:0] MODE_YEAR  = 3'd3;
  localparam logic [2:0] MODE_HOUR  = 3'd4;
  localparam logic [2:0] MODE_MIN   = 3'd5;
  localparam logic [2:0] MODE_SEC   = 3'd6;

  // Release flag codes
  localparam logic [1:0] FLAG_IDLE = 2'd0;
  localparam logic [1:0] FLAG_MODE = 2'd1;
  localparam logic [1:0] FLAG_UP   = 2'd2;
  localparam logic [1:0] FLAG_DOWN = 2'd3;

  // Operation codes
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Field limits
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [4:0] DAY_MIN   = 5'd1;
  localparam logic [3:0] MONTH_MIN = 4'd1;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] flag;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } cfsc_state_t;

  typedef struct packed {
    logic       write_valid;
    logic [2:0] field_select;
    logic [6:0] field_value;
  } cfsc_wr_t;

  // Days in a month, no leap years; zero for a month code that means nothing
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/cfsc_edit.sv]
// Next-state and write decode for one input word of the clock field editor.
// Pure combinational; uses cfsc_pkg types, codes and month_len.
`timescale 1ns / 1ps

module cfsc_edit (
  input  cfsc_pkg::cfsc_state_t cur,
  input  logic                  operation,
  input  logic                  mode_button,
  input  logic                  up_button,
  input  logic                  down_button,
  input  logic [5:0]            load_second,
  input  logic [5:0]            load_minute,
  input  logic [4:0]            load_hour,
  input  logic [4:0]            load_day,
  input  logic [3:0]            load_month,
  input  logic [6:0]            load_year,
  output cfsc_pkg::cfsc_state_t nxt,
  output cfsc_pkg::cfsc_wr_t    wr0,
  output cfsc_pkg::cfsc_wr_t    wr1,
  output logic                  has_two
);

  always_comb begin
    cfsc_pkg::cfsc_state_t st;
    logic [4:0] len;
    logic [4:0] dclamp;
    st      = cur;
    wr0     = '0;
    wr1     = '0;
    has_two = 1'b0;
    len     = 5'd0;
    dclamp  = 5'd0;
    if (operation == cfsc_pkg::OP_LOAD) begin
      st.sec   = load_second;
      st.min   = load_minute;
      st.hour  = load_hour;
      st.day   = load_day;
      st.month = load_month;
      st.year  = load_year;
    end else begin
      // buttons checked in order mode, up, down against the shared flag
      if (!mode_button) st.flag = cfsc_pkg::FLAG_MODE;
      if (mode_button && st.flag == cfsc_pkg::FLAG_MODE) begin
        st.mode = (st.mode >= cfsc_pkg::MODE_SEC) ? cfsc_pkg::MODE_RUN : st.mode + 3'd1;
        st.flag = cfsc_pkg::FLAG_IDLE;
      end

      if (!up_button) st.flag = cfsc_pkg::FLAG_UP;
      if (up_button && st.flag == cfsc_pkg::FLAG_UP && st.mode != cfsc_pkg::MODE_RUN &&
          st.mode <= cfsc_pkg::MODE_SEC) begin
        st.flag = cfsc_pkg::FLAG_IDLE;
        case (st.mode)
          cfsc_pkg::MODE_DAY: begin
            len = cfsc_pkg::month_len(st.month);
            if (len != 5'd0) begin
              st.day = (st.day >= len) ? len : st.day + 5'd1;
              wr0 = '{1'b1, cfsc_pkg::FS_DAY, {2'b00, st.day}};
            end
          end
          cfsc_pkg::MODE_MONTH: begin
            if (st.month >= cfsc_pkg::MONTH_MAX) begin
              st.month = cfsc_pkg::MONTH_MAX;
              wr0 = '{1'b1, cfsc_pkg::FS_MONTH, {3'b000, st.month}};
            end else begin
              // stored day stays; only the second word carries the clamp
              st.month = st.month + 4'd1;
              wr0 = '{1'b1, cfsc_pkg::FS_MONTH, {3'b000, st.month}};
              len = cfsc_pkg::month_len(st.month);
              dclamp = (st.day > len) ? len : st.day;
              wr1 = '{1'b1, cfsc_pkg::FS_DAY, {2'b00, dclamp}};
              has_two = 1'b1;
            end
          end
          cfsc_pkg::MODE_YEAR: begin
            st.year = (st.year >= cfsc_pkg::YEAR_MAX) ? cfsc_pkg::YEAR_MAX : st.year + 7'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_YEAR, st.year};
          end
          cfsc_pkg::MODE_HOUR: begin
            st.hour = (st.hour >= cfsc_pkg::HOUR_MAX) ? cfsc_pkg::HOUR_MAX : st.hour + 5'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_HOUR, {2'b00, st.hour}};
          end
          cfsc_pkg::MODE_MIN: begin
            st.min = (st.min >= cfsc_pkg::MIN_MAX) ? cfsc_pkg::MIN_MAX : st.min + 6'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_MIN, {1'b0, st.min}};
          end
          default: begin
            st.sec = (st.sec >= cfsc_pkg::SEC_MAX) ? cfsc_pkg::SEC_MAX : st.sec + 6'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_SEC, {1'b0, st.sec}};
          end
        endcase
      end

      if (!down_button) st.flag = cfsc_pkg::FLAG_DOWN;
      if (down_button && st.flag == cfsc_pkg::FLAG_DOWN && st.mode != cfsc_pkg::MODE_RUN &&
          st.mode <= cfsc_pkg::MODE_SEC) begin
        st.flag = cfsc_pkg::FLAG_IDLE;
        case (st.mode)
          cfsc_pkg::MODE_DAY: begin
            st.day = (st.day <= cfsc_pkg::DAY_MIN) ? cfsc_pkg::DAY_MIN : st.day - 5'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_DAY, {2'b00, st.day}};
          end
          cfsc_pkg::MODE_MONTH: begin
            st.month = (st.month <= cfsc_pkg::MONTH_MIN) ? cfsc_pkg::MONTH_MIN
                                                           : st.month - 4'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_MONTH, {3'b000, st.month}};
          end
          cfsc_pkg::MODE_YEAR: begin
            st.year = (st.year == 7'd0) ? 7'd0 : st.year - 7'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_YEAR, st.year};
          end
          cfsc_pkg::MODE_HOUR: begin
            st.hour = (st.hour == 5'd0) ? 5'd0 : st.hour - 5'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_HOUR, {2'b00, st.hour}};
          end
          cfsc_pkg::MODE_MIN: begin
            st.min = (st.min == 6'd0) ? 6'd0 : st.min - 6'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_MIN, {1'b0, st.min}};
          end
          default: begin
            st.sec = (st.sec == 6'd0) ? 6'd0 : st.sec - 6'd1;
            wr0 = '{1'b1, cfsc_pkg::FS_SEC, {1'b0, st.sec}};
          end
        endcase
      end
    end
    nxt = st;
  end

endmodule

[hw/rtl/clock_field_set_controller_unit.sv]
// Top level of the clock field set controller: stream ports, field state,
// output register with one pending slot. Uses cfsc_pkg and cfsc_edit.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | in_tdata (40b), in_tuser = operation
//   out_    | out | out_tvalid/out_tready| out_tdata (16b), out_tuser, out_tlast
//
// One input word is decoded in the cycle it is accepted; its results sit in
// the output register from the next cycle. A word may enter every cycle
// in_tready is high. A month raise makes two words: the second waits in a
// pending slot and blocks input. in_tready drops while a word stalls on
// out_tready or the slot is full. rst_n (synchronous) zeroes all fields.
`timescale 1ns / 1ps

module clock_field_set_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] mode_button, [1] up_button, [2] down_button, [8:3] load_second,
  // [14:9] load_minute, [19:15] load_hour, [24:20] load_day,
  // [28:25] load_month, [35:29] load_year, [39:36] zero
  input  logic [39:0] in_tdata,
  // [0] operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] field_select, [9:3] field_value, [12:10] edit_mode, [15:13] zero
  output logic [15:0] out_tdata,
  // [0] write_valid
  output logic        out_tuser,
  output logic        out_tlast
);

  cfsc_pkg::cfsc_state_t state_r, state_nxt;
  cfsc_pkg::cfsc_wr_t    wr0, wr1;
  cfsc_pkg::cfsc_wr_t    out_wr_r, pend_wr_r;
  logic                  has_two;
  logic                  out_valid_r, pend_r, out_last_r;
  logic [2:0]            out_mode_r;
  logic                  in_fire, out_fire;

  assign in_tready = !pend_r && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  cfsc_edit u_edit (
    .cur         (state_r),
    .operation   (in_tuser),
    .mode_button (in_tdata[0]),
    .up_button   (in_tdata[1]),
    .down_button (in_tdata[2]),
    .load_second (in_tdata[8:3]),
    .load_minute (in_tdata[14:9]),
    .load_hour   (in_tdata[19:15]),
    .load_day    (in_tdata[24:20]),
    .load_month  (in_tdata[28:25]),
    .load_year   (in_tdata[35:29]),
    .nxt         (state_nxt),
    .wr0         (wr0),
    .wr1         (wr1),
    .has_two     (has_two)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
        pend_r      <= has_two;
      end else if (out_fire) begin
        // advance the pending word, or drop the register
        out_valid_r <= pend_r;
        pend_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_wr_r   <= wr0;
      out_mode_r <= state_nxt.mode;
      out_last_r <= !has_two;
      pend_wr_r  <= wr1;
    end else if (out_fire && pend_r) begin
      out_wr_r   <= pend_wr_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_mode_r, out_wr_r.field_value, out_wr_r.field_select};
  assign out_tuser  = out_wr_r.write_valid;
  assign out_tlast  = out_last_r;

  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("pending word without an output word");

  a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pend_r) |-> !out_last_r)
    else $error("first of two words marked last");

  a_pend_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_tready)
    else $error("input taken while a second word waits");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode <= cfsc_pkg::MODE_SEC)
    else $error("edit mode out of range");

  a_two_then_day: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && has_two) |=> (pend_r && pend_wr_r.field_select == cfsc_pkg::FS_DAY))
    else $error("second word of a month raise is not a day write");

endmodule
